>>> hdl/assert_macros.svh
// Assertion macros shared by the sorted key/value table RTL.
// Self-contained; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SKV_ASSERT_IMPL(label, clk, rst, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error("same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define SKV_ASSERT_NEXT(label, clk, rst, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error("next-cycle check failed");

`endif

>>> hdl/skv_pkg.sv
// Package for the sorted key/value table: command and status codes,
// sequencer states and the structs passed between modules. No dependencies.
package skv_pkg;

  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_LOOKUP = 2'd1;
  localparam logic [1:0] MODE_READ   = 2'd2;
  localparam logic [1:0] MODE_CLEAR  = 2'd3;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_MISS  = 2'd2;
  localparam logic [1:0] STATUS_RANGE = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SHIFT,
    S_LK_STEP,
    S_LK_MID,
    S_LK_LOW,
    S_LK_HIGH,
    S_READ,
    S_RESP
  } state_t;

  typedef struct packed {
    logic eq;
    logic lt;
    logic gt;
  } cmp_res_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  position;
    logic [63:0] key;
    logic [63:0] value;
  } res_t;

endpackage

>>> hdl/skv_cmd_if.sv
// Command channel of the sorted key/value table: valid/ready plus payload.
// No dependencies.
interface skv_cmd_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [63:0] key;
  logic [63:0] value;
  logic [7:0]  index;

  modport source (output valid, mode, key, value, index, input ready);
  modport sink (input valid, mode, key, value, index, output ready);
endinterface

>>> hdl/skv_rsp_if.sv
// Response channel of the sorted key/value table: valid/ready plus payload.
// No dependencies.
interface skv_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [7:0]  position;
  logic [63:0] out_key;
  logic [63:0] out_value;

  modport source (output valid, status, position, out_key, out_value, input ready);
  modport sink (input valid, status, position, out_key, out_value, output ready);
endinterface

>>> hdl/sorted_key_value_table.sv
// Sorted key/value table. Commands arrive on the cmd channel (valid/ready);
// each command produces exactly one response transaction on rsp.
// Modes: insert a pair (placed after any equal keys), look up a key by binary
// search, read the entry at an index, or clear the table.
// The block handles one command at a time: cmd.ready is high only while the
// sequencer is idle. Steps from acceptance to the result being registered:
//   insert: shift each entry with a larger key up one place, one entry per
//           cycle, reading and writing the single memory port pair, then
//           write the new pair into the freed place;
//   lookup: binary search with the one comparator, probing the middle entry
//           while the window holds more than two entries, then its two ends;
//   read:   read the indexed entry; clear and refused commands: no steps.
// The sequencer returns to the idle state between consecutive commands.
// Reset (rst, synchronous, active high) empties the table at once; the storage
// itself is not cleared and needs no clearing pass.
// When the receiver stalls, the finished response waits in the rsp output
// register and the sequencer holds its next result until that register frees.
// Depends on skv_pkg, skv_cmd_if, skv_rsp_if and skv_seq.
module sorted_key_value_table
  import skv_pkg::*;
#(
  parameter int TABLE_DEPTH = 256,
  parameter int KEY_BYTES   = 8
) (
  input  logic      clk,
  input  logic      rst,
  skv_cmd_if.sink   cmd,
  skv_rsp_if.source rsp
);

  logic res_valid;
  logic res_take;
  res_t res;
  logic out_valid;
  res_t out_res;

  skv_seq #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .KEY_BYTES   (KEY_BYTES)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res       (res),
    .res_take  (res_take)
  );

  // The output register takes a new result whenever it is empty or its
  // current transaction completes in this cycle.
  assign res_take = res_valid && (!out_valid || rsp.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_res <= res;
    end
  end

  assign rsp.valid     = out_valid;
  assign rsp.status    = out_res.status;
  assign rsp.position  = out_res.position;
  assign rsp.out_key   = out_res.key;
  assign rsp.out_value = out_res.value;

endmodule

>>> hdl/skv_mem.sv
// Key and value storage: one write port, one read port with registered data.
// No dependencies.
module skv_mem #(
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [63:0]              wkey,
  input  logic [63:0]              wval,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [63:0]              rkey,
  output logic [63:0]              rval
);

  logic [63:0] key_mem [DEPTH];
  logic [63:0] val_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      key_mem[waddr] <= wkey;
      val_mem[waddr] <= wval;
    end
  end

  always_ff @(posedge clk) begin
    rkey <= key_mem[raddr];
    rval <= val_mem[raddr];
  end

endmodule

>>> hdl/skv_cmp.sv
// Shared key comparator used by both the insert shift and the binary search.
// Depends on skv_pkg.
module skv_cmp
  import skv_pkg::*;
(
  input  logic [63:0] a,
  input  logic [63:0] b,
  output cmp_res_t    res
);

  always_comb begin
    res.eq = (a == b);
    res.lt = (a < b);
    res.gt = (a > b);
  end

endmodule

>>> hdl/skv_seq.sv
// Sequencer of the sorted key/value table: runs insert shifts, binary search,
// indexed reads and clears over one memory and one comparator.
// Depends on skv_pkg, skv_cmd_if, skv_mem, skv_cmp and assert_macros.svh.
`include "assert_macros.svh"

module skv_seq
  import skv_pkg::*;
#(
  parameter int TABLE_DEPTH = 256,
  parameter int KEY_BYTES   = 8
) (
  input  logic     clk,
  input  logic     rst,
  skv_cmd_if.sink  cmd,
  output logic     res_valid,
  output res_t     res,
  input  logic     res_take
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int W  = (CW > 8) ? CW : 8;
  localparam logic [63:0] KEY_MASK = {64{1'b1}} << (64 - 8 * KEY_BYTES);

  state_t        state, state_next;
  logic [CW-1:0] count;
  logic [63:0]   k, v;
  logic [AW-1:0] p, l, r, cur;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [63:0]   wkey, wval, rd_key, rd_val;
  cmp_res_t      cmp;

  logic          full, shift_go, wide, idx_ok;
  logic [AW:0]   lr_sum;
  logic [AW-1:0] mid, idx_addr, count_addr, r_start;
  logic [W-1:0]  idx_w, cur_w, p_w;

  skv_mem #(.DEPTH(TABLE_DEPTH)) u_mem (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wkey  (wkey),
    .wval  (wval),
    .raddr (raddr),
    .rkey  (rd_key),
    .rval  (rd_val)
  );

  skv_cmp u_cmp (
    .a   (rd_key),
    .b   (k),
    .res (cmp)
  );

  always_comb begin
    full       = (count == CW'(TABLE_DEPTH));
    shift_go   = (p != '0) && cmp.gt;
    lr_sum     = {1'b0, l} + {1'b0, r};
    mid        = lr_sum[AW:1];
    wide       = ((r - l) > AW'(1));
    idx_w      = W'(cmd.index);
    idx_ok     = (idx_w < W'(count));
    idx_addr   = idx_w[AW-1:0];
    count_addr = count[AW-1:0];
    r_start    = count_addr - AW'(1);
    cur_w      = W'(cur);
    p_w        = W'(p);
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (cmd.valid) begin
          case (cmd.mode)
            MODE_INSERT: state_next = full ? S_RESP : S_SHIFT;
            MODE_LOOKUP: state_next = (count == '0) ? S_RESP : S_LK_STEP;
            MODE_READ:   state_next = idx_ok ? S_READ : S_RESP;
            default:     state_next = S_RESP;
          endcase
        end
      end
      S_SHIFT:   state_next = shift_go ? S_SHIFT : S_RESP;
      S_LK_STEP: state_next = wide ? S_LK_MID : S_LK_LOW;
      S_LK_MID:  state_next = cmp.eq ? S_RESP : S_LK_STEP;
      S_LK_LOW:  state_next = cmp.eq ? S_RESP : S_LK_HIGH;
      S_LK_HIGH: state_next = S_RESP;
      S_READ:    state_next = S_RESP;
      S_RESP:    state_next = res_take ? S_IDLE : S_RESP;
      default:   state_next = S_IDLE;
    endcase
  end

  // Memory port and handshake outputs.
  always_comb begin
    cmd.ready = 1'b0;
    res_valid = 1'b0;
    raddr     = cur;
    we        = 1'b0;
    waddr     = p;
    wkey      = rd_key;
    wval      = rd_val;
    case (state)
      S_IDLE: begin
        cmd.ready = 1'b1;
        // Prefetch the top entry for an insert, or the requested entry for a read.
        raddr = (cmd.mode == MODE_READ) ? idx_addr : r_start;
      end
      S_SHIFT: begin
        we = 1'b1;
        if (shift_go) begin
          raddr = p - AW'(2);
        end else begin
          wkey = k;
          wval = v;
        end
      end
      S_LK_STEP: raddr = wide ? mid : l;
      S_LK_LOW:  raddr = r;
      S_RESP:    res_valid = 1'b1;
      default:   raddr = cur;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      case (state)
        S_IDLE: begin
          if (cmd.valid) begin
            k <= cmd.key & KEY_MASK;
            v <= cmd.value;
            case (cmd.mode)
              MODE_INSERT: begin
                p   <= count_addr;
                res <= '{status: STATUS_FULL, position: '0, key: '0, value: '0};
              end
              MODE_LOOKUP: begin
                l   <= '0;
                r   <= r_start;
                res <= '{status: STATUS_MISS, position: '0, key: '0, value: '0};
              end
              MODE_READ: begin
                cur <= idx_addr;
                res <= '{status: STATUS_RANGE, position: '0, key: '0, value: '0};
              end
              default: begin
                count <= '0;
                res   <= '{status: STATUS_OK, position: '0, key: '0, value: '0};
              end
            endcase
          end
        end
        S_SHIFT: begin
          if (shift_go) begin
            p <= p - AW'(1);
          end else begin
            count <= count + CW'(1);
            res   <= '{status: STATUS_OK, position: p_w[7:0], key: k, value: v};
          end
        end
        S_LK_STEP: cur <= wide ? mid : l;
        S_LK_MID: begin
          if (cmp.eq) begin
            res <= '{status: STATUS_OK, position: cur_w[7:0], key: rd_key, value: rd_val};
          end else if (cmp.lt) begin
            l <= cur;
          end else begin
            r <= cur;
          end
        end
        S_LK_LOW: begin
          if (cmp.eq) begin
            res <= '{status: STATUS_OK, position: cur_w[7:0], key: rd_key, value: rd_val};
          end else begin
            cur <= r;
          end
        end
        S_LK_HIGH, S_READ: begin
          if (cmp.eq || state == S_READ) begin
            res <= '{status: STATUS_OK, position: cur_w[7:0], key: rd_key, value: rd_val};
          end
        end
        default: begin
        end
      endcase
    end
  end

  `SKV_ASSERT_IMPL(a_count_bound, clk, rst, 1'b1, count <= CW'(TABLE_DEPTH))
  `SKV_ASSERT_IMPL(a_shift_range, clk, rst, state == S_SHIFT,
    (CW'(p) <= count) && (count < CW'(TABLE_DEPTH)))
  `SKV_ASSERT_IMPL(a_window, clk, rst, state == S_LK_STEP, (l <= r) && (CW'(r) < count))
  `SKV_ASSERT_NEXT(a_insert_grows, clk, rst, state == S_SHIFT && !shift_go,
    count == $past(count) + CW'(1))
  `SKV_ASSERT_NEXT(a_res_hold, clk, rst, res_valid && !res_take,
    $stable(res) && state == S_RESP)

endmodule
